// ===== rtl/tcrt_pkg.sv =====
// Shared types and constants for the three-channel reload timer.
`default_nettype none
package tcrt_pkg;

  localparam int NUM_CHANNELS_DEF         = 3;
  localparam int CORE_TO_PERIPH_RATIO_DEF = 4;
  localparam int MAX_CYCLES_PER_TICK_DEF  = 255;

  localparam logic [15:0] UNDERFLOW_BIT = 16'h0100;
  localparam logic [15:0] UNIE_BIT      = 16'h0020;
  localparam logic [2:0]  SELECT_MASK   = 3'h7;
  localparam int          CLKOUT_DIV    = 3200;
  localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;

  localparam int DIV_W = 16;

  typedef enum logic [1:0] {
    FN_ADVANCE = 2'd0,
    FN_WRITE   = 2'd1,
    FN_READ    = 2'd2,
    FN_NOP     = 2'd3
  } func_t;

  localparam logic [3:0] REG_OUT_CTRL = 4'd0;
  localparam logic [3:0] REG_START    = 4'd1;
  localparam logic [3:0] REG_CAPTURE  = 4'd11;

  typedef enum logic [1:0] {
    KIND_CONST = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_CTRL  = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  // Classified command passed from front end to back end
  typedef struct packed {
    func_t       func;
    kind_t       kind;
    logic [3:0]  reg_sel;
    logic [1:0]  chan;
    logic [31:0] wdata;
    logic [11:0] cycles;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/tcrt_front.sv =====
// Front end: takes command words, decodes register selects, queues them.
`default_nettype none
module tcrt_front
  import tcrt_pkg::*;
#(
  parameter int NUM_CHANNELS        = NUM_CHANNELS_DEF,
  parameter int MAX_CYCLES_PER_TICK = MAX_CYCLES_PER_TICK_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [3:0]  in_reg_sel,
  input  wire logic [31:0] in_write_data,
  input  wire logic [7:0]  in_cycles,
  output logic             q_valid,
  output cmd_t             q_cmd,
  input  wire logic        q_pop,
  input  wire logic        back_busy
);

  localparam int DEPTH = 2;

  cmd_t       fifo_r [DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cmd;
  logic [3:0] off;
  logic       push;

  always_comb begin
    cmd         = '0;
    cmd.func    = func_t'(in_func);
    cmd.reg_sel = in_reg_sel;
    cmd.wdata   = in_write_data;
    cmd.kind    = KIND_OTHER;
    cmd.chan    = 2'd0;
    off         = in_reg_sel - 4'd2;
    if (32'(in_cycles) > 32'(MAX_CYCLES_PER_TICK)) cmd.cycles = 12'(MAX_CYCLES_PER_TICK);
    else cmd.cycles = 12'(in_cycles);
    // split select into channel and register kind
    if (in_reg_sel inside {[4'd2:4'd10]}) begin
      cmd.chan = (off >= 4'd6) ? 2'd2 : (off >= 4'd3) ? 2'd1 : 2'd0;
      case (off)
        4'd0, 4'd3, 4'd6: cmd.kind = KIND_CONST;
        4'd1, 4'd4, 4'd7: cmd.kind = KIND_COUNT;
        default:          cmd.kind = KIND_CTRL;
      endcase
      if (32'(cmd.chan) >= NUM_CHANNELS) cmd.kind = KIND_OTHER;
    end
  end

  // one item in flight: refuse while queued or executing
  assign busy    = (cnt_r != 2'd0) || back_busy;
  assign push    = start && !busy;
  assign q_valid = cnt_r != 2'd0;
  assign q_cmd   = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= cmd;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop && q_valid);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_busy_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> busy) else $error("busy not raised after accept");

endmodule
`default_nettype wire

// ===== rtl/tcrt_back.sv =====
// Back end: register file, prescalers and reload counters.
`default_nettype none
module tcrt_back
  import tcrt_pkg::*;
#(
  parameter int NUM_CHANNELS         = NUM_CHANNELS_DEF,
  parameter int CORE_TO_PERIPH_RATIO = CORE_TO_PERIPH_RATIO_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire cmd_t        q_cmd,
  output logic             q_pop,
  output logic             back_busy,
  output logic             out_valid,
  output logic [31:0]      out_read_data,
  output logic [2:0]       out_irq_raised,
  output logic [2:0]       out_irq_pending
);

  localparam int NCH = (NUM_CHANNELS > 3) ? 3 : NUM_CHANNELS;
  // quotients stay below 128: the sum is under divider + 256 and the divider is at least 4,
  // and a wrap count is under 128
  localparam int QB    = 7;
  localparam int NUM_W = DIV_W + 1;
  localparam int DEN_W = DIV_W + QB - 1;

  typedef enum logic [2:0] {S_IDLE, S_ADV, S_DIV, S_APPLY, S_RELOAD, S_DONE} state_t;

  state_t          state_r;
  cmd_t            cmd_r;
  logic [1:0]      ch_r;
  logic [31:0]     cnt_r   [NCH];
  logic [31:0]     rel_r   [NCH];
  logic [15:0]     ctl_r   [NCH];
  logic [DIV_W-1:0] acc_r  [NCH];
  logic [DIV_W-1:0] div_r  [NCH];
  logic [2:0]      start_r;
  logic [7:0]      octl_r;
  logic [2:0]      raised_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [QB-1:0]   quo_r;
  logic [2:0]      idx_r;
  logic            mod_r;

  function automatic logic [DIV_W-1:0] div_for(input logic [2:0] s,
                                               input logic [DIV_W-1:0] prev);
    logic [DIV_W-1:0] d;
    begin
      case (s)
        3'd0: d = DIV_W'(4 * CORE_TO_PERIPH_RATIO);
        3'd1: d = DIV_W'(16 * CORE_TO_PERIPH_RATIO);
        3'd2: d = DIV_W'(64 * CORE_TO_PERIPH_RATIO);
        3'd3: d = DIV_W'(256 * CORE_TO_PERIPH_RATIO);
        3'd4: d = DIV_W'(1024 * CORE_TO_PERIPH_RATIO);
        3'd6: d = DIV_W'(CLKOUT_DIV * CORE_TO_PERIPH_RATIO);
        default: d = prev;
      endcase
      return d;
    end
  endfunction

  // one channel at a time; a channel that reaches its divider runs a restoring
  // division, one quotient bit per cycle
  logic [NUM_W-1:0] sum;
  logic [31:0]      cur;
  logic [31:0]      wrap;
  logic             ch_on;
  logic             last_ch;
  logic [31:0]      rd_val;

  always_comb begin
    sum     = NUM_W'(acc_r[ch_r]) + NUM_W'(cmd_r.cycles);
    cur     = cnt_r[ch_r];
    ch_on   = start_r[ch_r];
    wrap    = 32'(quo_r) - cur - 32'd1;
    last_ch = 32'(ch_r) == NCH - 1;
  end

  always_comb begin
    rd_val = '0;
    if (q_cmd.func == FN_READ) begin
      if (q_cmd.reg_sel == REG_OUT_CTRL) rd_val = 32'(octl_r);
      else if (q_cmd.reg_sel == REG_START) rd_val = 32'(start_r);
      else case (q_cmd.kind)
        KIND_CONST: rd_val = rel_r[q_cmd.chan];
        KIND_COUNT: rd_val = cnt_r[q_cmd.chan];
        KIND_CTRL:  rd_val = 32'(ctl_r[q_cmd.chan]);
        default:    rd_val = '0;
      endcase
    end
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign back_busy = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      state_r  <= S_IDLE;
      start_r  <= 3'd0;
      octl_r   <= 8'd0;
      ch_r     <= 2'd0;
      raised_r <= 3'd0;
      for (int i = 0; i < NCH; i++) begin
        cnt_r[i] <= ALL_ONES;
        rel_r[i] <= ALL_ONES;
        ctl_r[i] <= '0;
        acc_r[i] <= '0;
        div_r[i] <= DIV_W'(4 * CORE_TO_PERIPH_RATIO);
      end
    end else begin
      out_valid <= state_r == S_DONE;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r    <= q_cmd;
            ch_r     <= 2'd0;
            raised_r <= 3'd0;
            out_read_data <= rd_val;
            if (q_cmd.func == FN_ADVANCE) begin
              state_r <= S_ADV;
            end else begin
              state_r <= S_DONE;
              if (q_cmd.func == FN_WRITE) begin
                if (q_cmd.reg_sel == REG_OUT_CTRL) octl_r <= q_cmd.wdata[7:0];
                else if (q_cmd.reg_sel == REG_START)
                  start_r <= q_cmd.wdata[2:0] & 3'((1 << NCH) - 1);
                else case (q_cmd.kind)
                  KIND_CONST: rel_r[q_cmd.chan] <= q_cmd.wdata;
                  KIND_COUNT: cnt_r[q_cmd.chan] <= q_cmd.wdata;
                  KIND_CTRL: begin
                    ctl_r[q_cmd.chan] <= q_cmd.wdata[15:0];
                    if ((q_cmd.wdata[2:0] & SELECT_MASK) != ctl_r[q_cmd.chan][2:0]) begin
                      div_r[q_cmd.chan] <= div_for(q_cmd.wdata[2:0], div_r[q_cmd.chan]);
                      acc_r[q_cmd.chan] <= '0;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end
        end
        S_ADV: begin
          if (ch_on && sum >= NUM_W'(div_r[ch_r])) begin
            num_r   <= sum;
            den_r   <= DEN_W'(div_r[ch_r]) << (QB - 1);
            quo_r   <= '0;
            idx_r   <= 3'(QB - 1);
            mod_r   <= 1'b0;
            state_r <= S_DIV;
          end else begin
            if (ch_on) acc_r[ch_r] <= sum[DIV_W-1:0];
            if (last_ch) state_r <= S_DONE;
            else ch_r <= ch_r + 2'd1;
          end
        end
        S_DIV: begin
          // take the largest quotient bit first
          if (DEN_W'(num_r) >= den_r) begin
            num_r <= num_r - NUM_W'(den_r);
            quo_r <= {quo_r[QB-2:0], 1'b1};
          end else begin
            quo_r <= {quo_r[QB-2:0], 1'b0};
          end
          den_r <= den_r >> 1;
          if (idx_r == 3'd0) state_r <= mod_r ? S_RELOAD : S_APPLY;
          else idx_r <= idx_r - 3'd1;
        end
        S_APPLY: begin
          acc_r[ch_r] <= num_r[DIV_W-1:0];
          if (32'(quo_r) > cur) begin
            // underflow: reload, flag, fold remaining ticks
            ctl_r[ch_r] <= ctl_r[ch_r] | UNDERFLOW_BIT;
            if ((ctl_r[ch_r] & UNIE_BIT) != '0) raised_r[ch_r] <= 1'b1;
            if (wrap > rel_r[ch_r]) begin
              // several reloads: end at reload - (wrap mod (reload + 1))
              num_r   <= NUM_W'(wrap);
              den_r   <= DEN_W'(rel_r[ch_r] + 32'd1) << (QB - 1);
              quo_r   <= '0;
              idx_r   <= 3'(QB - 1);
              mod_r   <= 1'b1;
              state_r <= S_DIV;
            end else begin
              cnt_r[ch_r] <= rel_r[ch_r] - wrap;
              if (last_ch) state_r <= S_DONE;
              else begin
                ch_r    <= ch_r + 2'd1;
                state_r <= S_ADV;
              end
            end
          end else begin
            cnt_r[ch_r] <= cur - 32'(quo_r);
            if (last_ch) state_r <= S_DONE;
            else begin
              ch_r    <= ch_r + 2'd1;
              state_r <= S_ADV;
            end
          end
        end
        S_RELOAD: begin
          cnt_r[ch_r] <= rel_r[ch_r] - 32'(num_r);
          if (last_ch) state_r <= S_DONE;
          else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_ADV;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_irq_raised  = raised_r;
    out_irq_pending = '0;
    for (int i = 0; i < NCH; i++)
      out_irq_pending[i] = ctl_r[i][8] && ctl_r[i][5];
  end

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE) else $error("strobe out of idle");
  a_no_raise_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cmd_r.func != FN_ADVANCE) |-> raised_r == 3'd0)
    else $error("raise on non-advance");

endmodule
`default_nettype wire

// ===== rtl/three_channel_reload_timer.sv =====
// Top level of the three-channel prescaled reload timer.
//  channel | ports                                    | handshake
//  input   | in_func in_reg_sel in_write_data in_cycles | start / busy
//  result  | out_read_data out_irq_raised out_irq_pending | out_valid strobe
// Register items go through the queue and the S_DONE state before the strobe is registered.
// Advance items visit the channels in turn; one that is stopped or below its divider only
// passes S_ADV, taking counts adds S_DIV and S_APPLY, wrapping more than once adds S_DIV and S_RELOAD.
// busy stays high until the strobe cycle; the next word can be taken at its end.
// rst_n is synchronous and restores every timer register to its reset value.
// The receiver cannot stall; each result is shown for one cycle only.
`default_nettype none
module three_channel_reload_timer
  import tcrt_pkg::*;
#(
  parameter int NUM_CHANNELS         = NUM_CHANNELS_DEF,
  parameter int CORE_TO_PERIPH_RATIO = CORE_TO_PERIPH_RATIO_DEF,
  parameter int MAX_CYCLES_PER_TICK  = MAX_CYCLES_PER_TICK_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [3:0]  in_reg_sel,
  input  wire logic [31:0] in_write_data,
  input  wire logic [7:0]  in_cycles,
  output logic             out_valid,
  output logic [31:0]      out_read_data,
  output logic [2:0]       out_irq_raised,
  output logic [2:0]       out_irq_pending
);

  logic q_valid, q_pop, back_busy;
  cmd_t q_cmd;

  tcrt_front #(.NUM_CHANNELS(NUM_CHANNELS), .MAX_CYCLES_PER_TICK(MAX_CYCLES_PER_TICK)) u_front (
    .clk, .rst_n, .start, .busy, .in_func, .in_reg_sel, .in_write_data, .in_cycles,
    .q_valid, .q_cmd, .q_pop, .back_busy
  );

  tcrt_back #(.NUM_CHANNELS(NUM_CHANNELS), .CORE_TO_PERIPH_RATIO(CORE_TO_PERIPH_RATIO)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .back_busy,
    .out_valid, .out_read_data, .out_irq_raised, .out_irq_pending
  );

endmodule
`default_nettype wire

// ===== test/tb_three_channel_reload_timer.sv =====
// Self-checking testbench for the three-channel prescaled reload timer.
`timescale 1ns / 1ps
module tb_three_channel_reload_timer;
  import tcrt_pkg::*;

  localparam int NCH   = 3;
  localparam int RATIO = 4;
  localparam int MAXC  = 255;
  localparam logic [3:0] REG_CONST0 = 4'd2;
  localparam logic [3:0] REG_COUNT0 = 4'd3;
  localparam logic [3:0] REG_CTRL0  = 4'd4;
  localparam int         REG_STRIDE = 3;
  localparam logic [3:0] REG_TOP    = 4'd15;

  typedef struct {
    func_t       func;
    logic [3:0]  sel;
    logic [31:0] wd;
    logic [7:0]  cyc;
  } word_t;

  typedef struct {
    logic [31:0] rd;
    logic [2:0]  raised;
    logic [2:0]  pending;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [3:0] in_reg_sel = '0;
  logic [31:0] in_write_data = '0;
  logic [7:0] in_cycles = '0;
  logic out_valid;
  logic [31:0] out_read_data;
  logic [2:0] out_irq_raised, out_irq_pending;

  three_channel_reload_timer uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_reg_sel(in_reg_sel), .in_write_data(in_write_data),
    .in_cycles(in_cycles), .out_valid(out_valid), .out_read_data(out_read_data),
    .out_irq_raised(out_irq_raised), .out_irq_pending(out_irq_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Timer model state
  logic [31:0] cnt [NCH];
  logic [31:0] rld [NCH];
  logic [15:0] ctl [NCH];
  int unsigned acc [NCH];
  int unsigned dvd [NCH];
  logic [2:0]  run_bits;
  logic [7:0]  oc_reg;

  word_t   words_q [$];
  status_t status_q [$];
  int      errors = 0;

  function automatic int unsigned divider_of(logic [2:0] s, int unsigned prev);
    if (s <= 3'd4) return (4 << (2 * s)) * RATIO;
    if (s == 3'd6) return CLKOUT_DIV * RATIO;
    return prev;
  endfunction

  function automatic void timer_reset();
    for (int c = 0; c < NCH; c++) begin
      cnt[c] = ALL_ONES;
      rld[c] = ALL_ONES;
      ctl[c] = '0;
      acc[c] = 0;
      dvd[c] = divider_of(3'd0, 0);
    end
    run_bits = '0;
    oc_reg = '0;
  endfunction

  function automatic status_t timer_step(word_t w);
    status_t r;
    int unsigned cy, ticks, c, k;
    logic [15:0] both;
    both = UNDERFLOW_BIT | UNIE_BIT;
    r.rd = '0;
    r.raised = '0;
    r.pending = '0;
    cy = (w.cyc > MAXC) ? MAXC : 32'(w.cyc);
    if (w.func == FN_ADVANCE) begin
      for (int ch = 0; ch < NCH; ch++) begin
        if (run_bits[ch] && dvd[ch] != 0) begin
          acc[ch] += cy;
          if (acc[ch] >= dvd[ch]) begin
            ticks = acc[ch] / dvd[ch];
            acc[ch] = acc[ch] % dvd[ch];
            // reload on every pass below zero
            while (longint'(ticks) > longint'(cnt[ch])) begin
              ticks -= cnt[ch] + 1;
              cnt[ch] = rld[ch];
              ctl[ch] |= UNDERFLOW_BIT;
              if ((ctl[ch] & UNIE_BIT) != 0) r.raised[ch] = 1'b1;
            end
            cnt[ch] -= ticks;
          end
        end
      end
    end else if (w.func == FN_WRITE || w.func == FN_READ) begin
      if (w.sel == REG_OUT_CTRL) begin
        if (w.func == FN_WRITE) oc_reg = w.wd[7:0];
        else r.rd = 32'(oc_reg);
      end else if (w.sel == REG_START) begin
        if (w.func == FN_WRITE) run_bits = w.wd[2:0];
        else r.rd = 32'(run_bits);
      end else if (w.sel >= REG_CONST0 && w.sel < REG_CAPTURE) begin
        c = (w.sel - REG_CONST0) / REG_STRIDE;
        k = (w.sel - REG_CONST0) % REG_STRIDE;
        if (k == 0) begin
          if (w.func == FN_WRITE) rld[c] = w.wd;
          else r.rd = rld[c];
        end else if (k == 1) begin
          if (w.func == FN_WRITE) cnt[c] = w.wd;
          else r.rd = cnt[c];
        end else if (w.func == FN_WRITE) begin
          if (w.wd[2:0] != ctl[c][2:0]) begin
            dvd[c] = divider_of(w.wd[2:0], dvd[c]);
            acc[c] = 0;
          end
          ctl[c] = w.wd[15:0];
        end else r.rd = 32'(ctl[c]);
      end
    end
    for (int ch = 0; ch < NCH; ch++)
      r.pending[ch] = ((ctl[ch] & both) == both);
    return r;
  endfunction

  function automatic void push_word(func_t f, logic [3:0] s, logic [31:0] d,
                                    logic [7:0] cy);
    word_t w;
    w.func = f;
    w.sel = s;
    w.wd = d;
    w.cyc = cy;
    words_q.push_back(w);
  endfunction

  // Driver
  word_t cur;
  int    gap_left = 0;
  bit    burst = 1'b0;
  always @(posedge clk) begin
    bit fire;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        status_q.push_back(timer_step(cur));
        if ($urandom_range(0, 29) == 0) burst = !burst;
        gap_left = burst ? 0 : $urandom_range(0, 4);
      end
      if (start && !fire) begin
        // hold the word until taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (words_q.size() > 0) begin
        cur = words_q.pop_front();
        in_func <= cur.func;
        in_reg_sel <= cur.sel;
        in_write_data <= cur.wd;
        in_cycles <= cur.cyc;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    status_t e;
    if (rst_n && out_valid) begin
      if (status_q.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = status_q.pop_front();
        if (out_read_data !== e.rd) begin
          $error("read_data expected %h actual %h", e.rd, out_read_data);
          errors++;
        end
        if (out_irq_raised !== e.raised) begin
          $error("irq_raised expected %b actual %b", e.raised, out_irq_raised);
          errors++;
        end
        if (out_irq_pending !== e.pending) begin
          $error("irq_pending expected %b actual %b", e.pending, out_irq_pending);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_data(logic [3:0] s);
    int unsigned k;
    k = $urandom_range(0, 9);
    if (s >= REG_CONST0 && s < REG_CAPTURE) begin
      if ((s - REG_CONST0) % REG_STRIDE == 2) begin
        // bias towards fast prescale selects and the enable bit
        return {$urandom} & ~32'h7 | (k < 7 ? $urandom_range(0, 1) : $urandom_range(0, 7))
               | (k < 6 ? UNIE_BIT : 32'h0);
      end
      if (k < 8) return $urandom_range(0, 40);
    end
    return $urandom;
  endfunction

  initial begin
    int unsigned k;
    logic [3:0] s;
    timer_reset();
    // directed part
    for (int r = 0; r <= REG_TOP; r++) push_word(FN_READ, 4'(r), '0, '0);
    push_word(FN_WRITE, REG_OUT_CTRL, ALL_ONES, 8'hff);
    push_word(FN_WRITE, REG_CAPTURE, ALL_ONES, '0);
    push_word(FN_WRITE, REG_TOP, ALL_ONES, '0);
    push_word(FN_NOP, REG_START, ALL_ONES, 8'hff);
    push_word(FN_WRITE, REG_CONST0, 32'd0, '0);
    push_word(FN_WRITE, REG_COUNT0, 32'd0, '0);
    push_word(FN_WRITE, REG_CTRL0, UNIE_BIT, '0);
    push_word(FN_WRITE, 4'(REG_CONST0 + REG_STRIDE), 32'd3, '0);
    push_word(FN_WRITE, 4'(REG_CTRL0 + REG_STRIDE), 32'h5, '0);
    push_word(FN_WRITE, 4'(REG_CTRL0 + 2 * REG_STRIDE), 32'hffff_fff6, '0);
    push_word(FN_WRITE, REG_START, ALL_ONES, '0);
    push_word(FN_ADVANCE, '0, ALL_ONES, 8'd255);
    push_word(FN_ADVANCE, '0, '0, 8'd16);
    push_word(FN_WRITE, 4'(REG_CTRL0 + REG_STRIDE), 32'h7, '0);
    push_word(FN_ADVANCE, '0, '0, 8'd0);
    push_word(FN_WRITE, REG_CTRL0, 32'h0, '0);
    push_word(FN_READ, 4'(REG_CTRL0 + 2 * REG_STRIDE), '0, '0);
    // random part
    for (int i = 0; i < 1300; i++) begin
      k = $urandom_range(0, 99);
      s = 4'($urandom_range(0, 15));
      if (k < 50) push_word(FN_ADVANCE, s, $urandom, 8'($urandom));
      else if (k < 80) push_word(FN_WRITE, s, rand_data(s), 8'($urandom));
      else if (k < 95) push_word(FN_READ, s, $urandom, 8'($urandom));
      else push_word(FN_NOP, s, $urandom, 8'($urandom));
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (words_q.size() > 0 || start || status_q.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) begin
      $display("three_channel_reload_timer verification clean");
    end else begin
      $display("three_channel_reload_timer verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("three_channel_reload_timer verification failed");
    $finish;
  end

endmodule
